/* rtl/tfg_pkg.sv */
package tfg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FQ_DEPTH  = 4;
  localparam int SQRT_STG  = 64;
  localparam int DIV_STG   = 31;
  localparam int PRE_STG   = 7;
  localparam int POST_STG  = 4;
  localparam int NUM_STG   = PRE_STG + SQRT_STG + DIV_STG + POST_STG;
  localparam int DIV3_SH   = 35;
  localparam logic [33:0] DIV3_K = 34'h2AAAAAAAB;
  localparam logic [65:0] Q30_RND = 66'h3FFFFFFF;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
  } face_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] unit_nx;
    logic signed [31:0] unit_ny;
    logic signed [31:0] unit_nz;
    logic signed [31:0] plane_distance;
    logic [47:0]        face_area;
    logic               degenerate;
  } geom_t;

  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][32:0] u;
    logic [2:0][32:0] v;
    logic [2:0][33:0] s;
    logic [2:0][33:0] wmag;
    logic [2:0]       wneg;
  } fe_t;

  typedef struct packed {
    logic [2:0][31:0] center;
    logic [2:0][63:0] m;
    logic [2:0]       sgn;
    logic             big;
    logic             degen;
    logic [2:0][31:0] a;
  } tag_t;

endpackage

/* rtl/triangle_face_geometry.sv */
// Face geometry engine: one triangle face with its opposite vertex per request.
// Input channel: a face request is taken at a clock edge where push is high and
// full is low. Result channel: the oldest result sits on geom while empty is
// low, and it is taken at an edge where pop is high.
// Each result gives the barycenter, the unit normal pointing away from the
// opposite vertex, the plane distance and the face area; a zero cross
// product sets degenerate and zeroes normal, distance and area.
// Throughput is one request per cycle while the result queue does not fill. On
// its way to geom an accepted request passes a four-entry input queue,
// a 7-stage multiply front end, a 64-stage square root pipeline, a 31-stage
// normalizing divider and 4 stages of distance and area logic.
// When pop is held low the two-entry result queue fills, the whole back
// pipeline holds, then the input queue fills and full rises.
// Reset (rst, synchronous) empties both queues and drops every request in flight.
module triangle_face_geometry (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tfg_pkg::face_t face,
  output logic           empty,
  input  logic           pop,
  output tfg_pkg::geom_t geom
);
  import tfg_pkg::*;

  logic fvalid;
  logic fpop;
  fe_t  fdata;

  tfg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .face   (face),
    .fvalid (fvalid),
    .fpop   (fpop),
    .fdata  (fdata)
  );

  tfg_back u_back (
    .clk    (clk),
    .rst    (rst),
    .fvalid (fvalid),
    .fpop   (fpop),
    .fdata  (fdata),
    .empty  (empty),
    .pop    (pop),
    .geom   (geom)
  );

endmodule

/* rtl/tfg_front.sv */
module tfg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tfg_pkg::face_t face,
  output logic           fvalid,
  input  logic           fpop,
  output tfg_pkg::fe_t   fdata
);
  import tfg_pkg::*;

  localparam int AW = $clog2(FQ_DEPTH);
  localparam int CW = $clog2(FQ_DEPTH + 1);

  fe_t           qmem [FQ_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  fe_t           ent;
  logic          wr;
  logic          rd;
  logic [31:0]   av [3];
  logic [31:0]   bv [3];
  logic [31:0]   cv [3];
  logic [31:0]   dv [3];
  logic [34:0]   w  [3];

  assign av = '{face.a_x, face.a_y, face.a_z};
  assign bv = '{face.b_x, face.b_y, face.b_z};
  assign cv = '{face.c_x, face.c_y, face.c_z};
  assign dv = '{face.d_x, face.d_y, face.d_z};

  always_comb begin
    ent = '0;
    for (int i = 0; i < 3; i++) begin
      ent.a[i] = av[i];
      ent.u[i] = {bv[i][31], bv[i]} - {av[i][31], av[i]};
      ent.v[i] = {cv[i][31], cv[i]} - {av[i][31], av[i]};
      ent.s[i] = {{2{av[i][31]}}, av[i]} + {{2{bv[i][31]}}, bv[i]}
               + {{2{cv[i][31]}}, cv[i]};
      w[i] = {ent.s[i][33], ent.s[i]} - {{2{dv[i][31]}}, dv[i], 1'b0}
           - {{3{dv[i][31]}}, dv[i]};
      ent.wneg[i] = w[i][34];
      ent.wmag[i] = w[i][34] ? 34'(-w[i]) : w[i][33:0];
    end
  end

  assign full   = (cnt == CW'(FQ_DEPTH));
  assign fvalid = (cnt != '0);
  assign fdata  = qmem[rp];
  assign wr     = push && !full;
  assign rd     = fpop && fvalid;

  always_ff @(posedge clk) begin
    if (wr) begin
      qmem[wp] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + CW'(wr) - CW'(rd);
    end
  end

endmodule

/* rtl/tfg_sqrt.sv */
module tfg_sqrt (
  input  logic         clk,
  input  logic         en,
  input  logic [127:0] rad,
  output logic [63:0]  root
);
  import tfg_pkg::*;

  logic [127:0] rad_q  [SQRT_STG];
  logic [64:0]  rem_q  [SQRT_STG];
  logic [63:0]  root_q [SQRT_STG];

  for (genvar k = 0; k < SQRT_STG; k++) begin : g_stg
    logic [127:0] rad_p;
    logic [64:0]  rem_p;
    logic [63:0]  root_p;
    logic [66:0]  r4;
    logic [66:0]  trial;
    if (k == 0) begin : g_first
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end
    assign r4    = {rem_p, rad_p[127:126]};
    assign trial = {1'b0, root_p, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k] <= {rad_p[125:0], 2'b00};
        if (r4 >= trial) begin
          rem_q[k]  <= 65'(r4 - trial);
          root_q[k] <= {root_p[62:0], 1'b1};
        end else begin
          rem_q[k]  <= r4[64:0];
          root_q[k] <= {root_p[62:0], 1'b0};
        end
      end
    end
  end

  assign root = root_q[SQRT_STG-1];

endmodule

/* rtl/tfg_div.sv */
module tfg_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] m,
  input  logic [63:0] len,
  output logic [30:0] q,
  output logic [63:0] len_o
);
  import tfg_pkg::*;

  logic [63:0] r_q   [DIV_STG];
  logic [30:0] q_q   [DIV_STG];
  logic [63:0] len_q [DIV_STG];

  always_ff @(posedge clk) begin
    if (en) begin
      len_q[0] <= len;
      if (m >= len) begin
        r_q[0] <= '0;
        q_q[0] <= 31'd1;
      end else begin
        r_q[0] <= m;
        q_q[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k < DIV_STG; k++) begin : g_stg
    logic [64:0] r2;
    assign r2 = {r_q[k-1], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        len_q[k] <= len_q[k-1];
        if (r2 >= {1'b0, len_q[k-1]}) begin
          r_q[k] <= 64'(r2 - {1'b0, len_q[k-1]});
          q_q[k] <= {q_q[k-1][29:0], 1'b1};
        end else begin
          r_q[k] <= r2[63:0];
          q_q[k] <= {q_q[k-1][29:0], 1'b0};
        end
      end
    end
  end

  assign q     = q_q[DIV_STG-1];
  assign len_o = len_q[DIV_STG-1];

endmodule

/* rtl/tfg_back.sv */
module tfg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           fvalid,
  output logic           fpop,
  input  tfg_pkg::fe_t   fdata,
  output logic           empty,
  input  logic           pop,
  output tfg_pkg::geom_t geom
);
  import tfg_pkg::*;

  localparam int SD = SQRT_STG + DIV_STG;

  logic               en;
  logic [NUM_STG-1:0] vld;

  logic signed [32:0] uu [3];
  logic signed [32:0] vv [3];
  logic [32:0]        smag [3];

  logic signed [65:0] p [6];
  logic [66:0]        cprod [3];
  logic [2:0]         csg;
  logic [33:0]        wm1 [3];
  logic [33:0]        wm2 [3];
  logic [33:0]        wm3 [3];
  logic [2:0]         wn1;
  logic [2:0]         wn2;
  logic [2:0]         wn3;
  tag_t               tag1;
  tag_t               tag2;
  tag_t               tag3;
  tag_t               tag4;
  tag_t               tag5;
  tag_t               tag6;
  tag_t               tag7;
  tag_t               tag1_next;
  tag_t               tag2_next;
  tag_t               tag3_next;
  tag_t               tag4_next;
  tag_t               tag7_next;

  logic signed [65:0] n [3];
  logic [31:0]        cq [3];
  logic [64:0]        mg [3];
  logic [66:0]        dl [3];
  logic [65:0]        dh [3];
  logic [2:0]         dsg4;
  logic [2:0]         dsg5;
  logic [98:0]        dterm [3];
  logic [63:0]        sll [3];
  logic [63:0]        slh [3];
  logic [63:0]        shh [3];
  logic signed [99:0] dsig [3];
  logic [127:0]       sqi [3];
  logic signed [101:0] dsum;
  logic [127:0]       sq7;
  logic               big_c;

  tag_t               sd [SD];
  logic [63:0]        root;
  logic [30:0]        qd [3];
  logic [63:0]        len_o;
  tag_t               tg;
  logic [63:0]        ash;

  logic [31:0]        unit1 [3];
  logic [31:0]        unit2 [3];
  logic [31:0]        unit3 [3];
  logic [47:0]        area1;
  logic [47:0]        area2;
  logic [47:0]        area3;
  logic [2:0][31:0]   cen1;
  logic [2:0][31:0]   cen2;
  logic [2:0][31:0]   cen3;
  logic [2:0][31:0]   a1;
  logic               dg1;
  logic               dg2;
  logic               dg3;
  logic signed [63:0] prod [3];
  logic signed [65:0] acc;
  logic signed [65:0] accr;
  logic signed [35:0] dsh;
  logic [31:0]        dist_sat;
  geom_t              res;

  geom_t              oq [2];
  logic               owp;
  logic               orp;
  logic [1:0]         ocnt;
  logic               opush;
  logic               opop;

  assign en   = !(vld[NUM_STG-1] && (ocnt == 2'd2));
  assign fpop = en && fvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STG-2:0], fvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uu[i]   = $signed(fdata.u[i]);
      vv[i]   = $signed(fdata.v[i]);
      smag[i] = fdata.s[i][33] ? 33'(-fdata.s[i]) : fdata.s[i][32:0];
    end
  end

  always_comb begin
    tag1_next   = '0;
    tag1_next.a = fdata.a;
    tag2_next   = tag1;
    tag3_next   = tag2;
    tag4_next   = tag3;
    tag4_next.big   = big_c;
    tag4_next.degen = (mg[0] == '0) && (mg[1] == '0) && (mg[2] == '0);
    for (int i = 0; i < 3; i++) begin
      tag2_next.center[i] = csg[i] ? -cq[i] : cq[i];
      tag3_next.sgn[i]    = n[i][65];
      tag4_next.m[i]      = big_c ? {1'b0, mg[i][64:2]} : mg[i][63:0];
    end
    tag7_next     = tag6;
    tag7_next.sgn = tag6.sgn ^ {3{dsum[101]}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= uu[1] * vv[2];
      p[1] <= uu[2] * vv[1];
      p[2] <= uu[2] * vv[0];
      p[3] <= uu[0] * vv[2];
      p[4] <= uu[0] * vv[1];
      p[5] <= uu[1] * vv[0];
      tag1 <= tag1_next;
      for (int i = 0; i < 3; i++) begin
        cprod[i] <= smag[i] * DIV3_K;
        csg[i]   <= fdata.s[i][33];
        wm1[i]   <= fdata.wmag[i];
      end
      wn1 <= fdata.wneg;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cq[i] = cprod[i][DIV3_SH+31:DIV3_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n[0] <= p[0] - p[1];
      n[1] <= p[2] - p[3];
      n[2] <= p[4] - p[5];
      tag2 <= tag2_next;
      for (int i = 0; i < 3; i++) begin
        wm2[i] <= wm1[i];
      end
      wn2 <= wn1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3 <= tag3_next;
      for (int i = 0; i < 3; i++) begin
        mg[i]  <= n[i][65] ? 65'(-n[i]) : 65'(n[i]);
        wm3[i] <= wm2[i];
      end
      wn3 <= wn2;
    end
  end

  assign big_c = mg[0][64] || mg[0][63] || mg[1][64] || mg[1][63]
              || mg[2][64] || mg[2][63];

  always_ff @(posedge clk) begin
    if (en) begin
      tag4 <= tag4_next;
      for (int i = 0; i < 3; i++) begin
        dl[i]   <= mg[i][32:0] * wm3[i];
        dh[i]   <= mg[i][64:33] * wm3[i];
        dsg4[i] <= tag3.sgn[i] ^ wn3[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag5 <= tag4;
      dsg5 <= dsg4;
      for (int i = 0; i < 3; i++) begin
        dterm[i] <= {dh[i], 33'd0} + 99'(dl[i]);
        sll[i]   <= tag4.m[i][31:0] * tag4.m[i][31:0];
        slh[i]   <= tag4.m[i][31:0] * tag4.m[i][63:32];
        shh[i]   <= tag4.m[i][63:32] * tag4.m[i][63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag6 <= tag5;
      for (int i = 0; i < 3; i++) begin
        dsig[i] <= dsg5[i] ? -$signed({1'b0, dterm[i]}) : $signed({1'b0, dterm[i]});
        sqi[i]  <= {shh[i], 64'd0} + {31'd0, slh[i], 33'd0} + {64'd0, sll[i]};
      end
    end
  end

  assign dsum = 102'(dsig[0]) + 102'(dsig[1]) + 102'(dsig[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      tag7 <= tag7_next;
      sq7  <= sqi[0] + sqi[1] + sqi[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= tag7;
      for (int k = 1; k < SD; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  tfg_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq7),
    .root (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [63:0] lo_unused;
    tfg_div u_div (
      .clk   (clk),
      .en    (en),
      .m     (sd[SQRT_STG-1].m[i]),
      .len   (root),
      .q     (qd[i]),
      .len_o (lo_unused)
    );
    if (i == 0) begin : g_len
      assign len_o = lo_unused;
    end
  end

  assign tg  = sd[SD-1];
  assign ash = tg.big ? (len_o >> (FRAC_BITS - 1)) : (len_o >> (FRAC_BITS + 1));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (tg.degen) begin
          unit1[i] <= '0;
        end else if (tg.sgn[i]) begin
          unit1[i] <= -{1'b0, qd[i]};
        end else begin
          unit1[i] <= {1'b0, qd[i]};
        end
      end
      if (tg.degen) begin
        area1 <= '0;
      end else if (ash[63:48] != '0) begin
        area1 <= '1;
      end else begin
        area1 <= ash[47:0];
      end
      cen1 <= tg.center;
      a1   <= tg.a;
      dg1  <= tg.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod[i]  <= $signed(unit1[i]) * $signed(a1[i]);
        unit2[i] <= unit1[i];
        unit3[i] <= unit2[i];
      end
      area2 <= area1;
      area3 <= area2;
      cen2  <= cen1;
      cen3  <= cen2;
      dg2   <= dg1;
      dg3   <= dg2;
      acc   <= 66'(prod[0]) + 66'(prod[1]) + 66'(prod[2]);
    end
  end

  assign accr = acc[65] ? acc + $signed(Q30_RND) : acc;
  assign dsh  = 36'(accr >>> 30);

  always_comb begin
    if (dsh > 36'sd2147483647) begin
      dist_sat = 32'h7FFFFFFF;
    end else if (dsh < -36'sd2147483648) begin
      dist_sat = 32'h80000000;
    end else begin
      dist_sat = dsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.center_x       <= cen3[0];
      res.center_y       <= cen3[1];
      res.center_z       <= cen3[2];
      res.unit_nx        <= unit3[0];
      res.unit_ny        <= unit3[1];
      res.unit_nz        <= unit3[2];
      res.plane_distance <= dist_sat;
      res.face_area      <= area3;
      res.degenerate     <= dg3;
    end
  end

  assign opush = en && vld[NUM_STG-1];
  assign opop  = pop && (ocnt != 2'd0);
  assign empty = (ocnt == 2'd0);
  assign geom  = oq[orp];

  always_ff @(posedge clk) begin
    if (opush) begin
      oq[owp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= '0;
    end else begin
      if (opush) begin
        owp <= ~owp;
      end
      if (opop) begin
        orp <= ~orp;
      end
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

endmodule

/* rtl/tfg_chk.sv */
module tfg_chk (
  input logic           clk,
  input logic           rst,
  input logic           push,
  input logic           full,
  input tfg_pkg::face_t face,
  input logic           empty,
  input logic           pop,
  input tfg_pkg::geom_t geom
);
  import tfg_pkg::*;

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && geom.degenerate) |-> (geom.unit_nx == 0 && geom.unit_ny == 0 &&
      geom.unit_nz == 0 && geom.plane_distance == 0 && geom.face_area == 0))
    else $error("degenerate result with nonzero normal, distance or area");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (geom.unit_nx <= 32'sd1073741824 && geom.unit_nx >= -32'sd1073741824 &&
      geom.unit_ny <= 32'sd1073741824 && geom.unit_ny >= -32'sd1073741824 &&
      geom.unit_nz <= 32'sd1073741824 && geom.unit_nz >= -32'sd1073741824))
    else $error("unit normal component out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(geom)))
    else $error("stalled result changed");

endmodule

bind triangle_face_geometry tfg_chk u_chk (.*);
